// ----- rtl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Constants, control word layout and microcode table of the rc4 keystream
// generator.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 8 * MAX_KEY_BYTES;
    localparam int KIDX_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int LEN_W         = 4;
    localparam int CNT_W         = 4;
    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int STEP_W        = 4;

    localparam logic [BYTE_W-1:0] POS_LAST = 8'd255;
    localparam logic [CNT_W-1:0]  MAX_RESULTS = 4'd8;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;

    // program steps
    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_FILL  = 4'd1;
    localparam logic [STEP_W-1:0] ST_KS0   = 4'd2;
    localparam logic [STEP_W-1:0] ST_KS1   = 4'd3;
    localparam logic [STEP_W-1:0] ST_KS2   = 4'd4;
    localparam logic [STEP_W-1:0] ST_KS3   = 4'd5;
    localparam logic [STEP_W-1:0] ST_KSEND = 4'd6;
    localparam logic [STEP_W-1:0] ST_G0    = 4'd7;
    localparam logic [STEP_W-1:0] ST_G1    = 4'd8;
    localparam logic [STEP_W-1:0] ST_G2    = 4'd9;
    localparam logic [STEP_W-1:0] ST_G3    = 4'd10;
    localparam logic [STEP_W-1:0] ST_G4    = 4'd11;

    // read address select
    localparam logic [2:0] RA_POS   = 3'd0;
    localparam logic [2:0] RA_KSJ   = 3'd1;
    localparam logic [2:0] RA_INC_I = 3'd2;
    localparam logic [2:0] RA_GENJ  = 3'd3;
    localparam logic [2:0] RA_SUM   = 3'd4;

    // write address select
    localparam logic [1:0] WA_POS = 2'd0;
    localparam logic [1:0] WA_I   = 2'd1;
    localparam logic [1:0] WA_J   = 2'd2;

    // write data select
    localparam logic [1:0] WD_POS = 2'd0;
    localparam logic [1:0] WD_RD  = 2'd1;
    localparam logic [1:0] WD_A   = 2'd2;

    // j update
    localparam logic [1:0] JU_HOLD  = 2'd0;
    localparam logic [1:0] JU_CLEAR = 2'd1;
    localparam logic [1:0] JU_KS    = 2'd2;
    localparam logic [1:0] JU_GEN   = 2'd3;

    // sequencing conditions
    localparam logic [2:0] SQ_NEXT   = 3'd0;
    localparam logic [2:0] SQ_ACCEPT = 3'd1;
    localparam logic [2:0] SQ_POS    = 3'd2;
    localparam logic [2:0] SQ_COUNT  = 3'd3;
    localparam logic [2:0] SQ_EMIT   = 3'd4;

    typedef struct packed {
        logic [2:0]        rd_sel;
        logic              we;
        logic [1:0]        wa_sel;
        logic [1:0]        wd_sel;
        logic              ld_a;
        logic              ld_b;
        logic              ld_fwd;
        logic [1:0]        j_upd;
        logic              inc_i;
        logic              clr_i;
        logic              inc_pos;
        logic              step_k;
        logic              clr_k;
        logic              set_seeded;
        logic              emit;
        logic [2:0]        seq;
        logic [STEP_W-1:0] target;
    } uword_t;

    function automatic uword_t rc4_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '0;
        w.rd_sel = RA_POS;
        w.seq    = SQ_NEXT;
        w.target = ST_IDLE;
        unique case (step)
            ST_IDLE:
            begin
                w.seq = SQ_ACCEPT;
                w.target = ST_FILL;
            end
            ST_FILL:
            begin
                w.we = 1'b1;
                w.wa_sel = WA_POS;
                w.wd_sel = WD_POS;
                w.inc_pos = 1'b1;
                w.j_upd = JU_CLEAR;
                w.clr_k = 1'b1;
                w.seq = SQ_POS;
                w.target = ST_FILL;
            end
            ST_KS0:
            begin
                w.rd_sel = RA_POS;
            end
            ST_KS1:
            begin
                w.rd_sel = RA_KSJ;
                w.ld_a = 1'b1;
                w.j_upd = JU_KS;
            end
            ST_KS2:
            begin
                w.we = 1'b1;
                w.wa_sel = WA_POS;
                w.wd_sel = WD_RD;
            end
            ST_KS3:
            begin
                w.we = 1'b1;
                w.wa_sel = WA_J;
                w.wd_sel = WD_A;
                w.inc_pos = 1'b1;
                w.step_k = 1'b1;
                w.seq = SQ_POS;
                w.target = ST_KS0;
            end
            ST_KSEND:
            begin
                w.clr_i = 1'b1;
                w.j_upd = JU_CLEAR;
                w.set_seeded = 1'b1;
                w.seq = SQ_COUNT;
                w.target = ST_IDLE;
            end
            ST_G0:
            begin
                w.rd_sel = RA_INC_I;
                w.inc_i = 1'b1;
            end
            ST_G1:
            begin
                w.rd_sel = RA_GENJ;
                w.ld_a = 1'b1;
                w.j_upd = JU_GEN;
            end
            ST_G2:
            begin
                w.ld_b = 1'b1;
                w.we = 1'b1;
                w.wa_sel = WA_I;
                w.wd_sel = WD_RD;
            end
            ST_G3:
            begin
                w.we = 1'b1;
                w.wa_sel = WA_J;
                w.wd_sel = WD_A;
                w.rd_sel = RA_SUM;
                w.ld_fwd = 1'b1;
            end
            ST_G4:
            begin
                w.rd_sel = RA_SUM;
                w.emit = 1'b1;
                w.seq = SQ_EMIT;
                w.target = ST_G0;
            end
            default:
            begin
                w.seq = SQ_NEXT;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/rc4_keystream_generator.sv -----
// ----------------------------------------------------------------------------
// rc4_keystream_generator
// RC4 keystream byte generator run by a small microcoded sequencer over a
// 256 x 8 permutation memory with one read port and one write port.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*    : key bytes (index 0, byte 0 in bits 7:0) and key length
//              (index 1, 1..8). Write only while the block is idle.
//   s_axis_* : one request item: byte_count in tdata[3:0], reseed in tuser.
//   m_axis_* : one keystream byte per item in tdata, tlast on the last byte
//              of a request.
// Sequence, set by the microcode:
//   reseed: identity fill of all 256 entries, then the key schedule over all
//   256 positions and a closing step before the first byte starts.
//   each byte runs the index update, two reads, two writes and the output
//   lookup in turn; a request without reseed goes from idle straight to them.
//   The first request after reset always runs the key schedule.
// s_axis_tready is high only when the sequencer sits in its idle step; a new
// request may be taken while the last byte of the previous one still waits in
// the output register. A stalled receiver holds the sequencer in its output
// step until the byte is taken.
// Reset clears indices, seeded flag, counters and output valid; the
// permutation memory is not cleared and is always rebuilt before use.
// ----------------------------------------------------------------------------
module rc4_keystream_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rc4_pkg::KEY_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [3:0] byte_count, [7:4] zero
    input  logic                             s_axis_tuser,   // [0] reseed
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] random_byte
    output logic                             m_axis_tlast
);
    import rc4_pkg::*;

    // configuration
    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg;

    // sequencer
    logic [STEP_W-1:0] upc_reg, upc_next;
    uword_t            uw;

    // datapath
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [KIDX_W-1:0] k_reg, k_next;
    logic [BYTE_W-1:0] a_reg, a_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic              fwd_reg, fwd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              seeded_reg, seeded_next;

    // output register
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] odata_reg, odata_next;
    logic              olast_reg, olast_next;

    // permutation memory
    logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] rd_addr;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              wr_en;

    logic              accept;
    logic              emit_ok;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] ks_j;
    logic [BYTE_W-1:0] gen_j;
    logic [BYTE_W-1:0] inc_i;
    logic [BYTE_W-1:0] sum_ab;
    logic [LEN_W-1:0]  key_len_eff;
    logic [LEN_W-1:0]  k_plus1;
    logic [CNT_W-1:0]  req_cnt;

    assign uw       = rc4_rom(upc_reg);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign emit_ok  = !ovalid_reg || m_axis_tready;
    assign key_byte = key_reg[{k_reg, 3'b000} +: BYTE_W];
    assign ks_j     = j_reg + rd_data_reg + key_byte;
    assign gen_j    = j_reg + rd_data_reg;
    assign inc_i    = i_reg + 8'd1;
    assign sum_ab   = a_reg + b_reg;
    assign k_plus1  = LEN_W'(k_reg) + 4'd1;
    assign req_cnt  = (s_axis_tdata[3:0] > MAX_RESULTS) ? MAX_RESULTS : s_axis_tdata[3:0];

    always_comb
    begin
        if (len_reg == '0)
            key_len_eff = 4'd1;
        else if (len_reg > LEN_W'(MAX_KEY_BYTES))
            key_len_eff = LEN_W'(MAX_KEY_BYTES);
        else
            key_len_eff = len_reg;
    end

    assign s_axis_tready = (upc_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    // memory address and data selection
    always_comb
    begin
        unique case (uw.rd_sel)
            RA_KSJ:   rd_addr = ks_j;
            RA_INC_I: rd_addr = inc_i;
            RA_GENJ:  rd_addr = gen_j;
            RA_SUM:   rd_addr = sum_ab;
            default:  rd_addr = pos_reg;
        endcase
        unique case (uw.wa_sel)
            WA_I:    wr_addr = i_reg;
            WA_J:    wr_addr = j_reg;
            default: wr_addr = pos_reg;
        endcase
        unique case (uw.wd_sel)
            WD_RD:   wr_data = rd_data_reg;
            WD_A:    wr_data = a_reg;
            default: wr_data = pos_reg;
        endcase
        wr_en = uw.we;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            perm_mem[wr_addr] <= wr_data;
        rd_data_reg <= perm_mem[rd_addr];
    end

    // datapath and sequencer next state
    always_comb
    begin
        i_next      = i_reg;
        j_next      = j_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        fwd_next    = fwd_reg;
        cnt_next    = cnt_reg;
        seeded_next = seeded_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        upc_next    = upc_reg + 4'd1;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        if (uw.inc_i)
            i_next = inc_i;
        if (uw.clr_i)
            i_next = '0;
        if (uw.inc_pos)
            pos_next = pos_reg + 8'd1;
        if (uw.clr_k)
            k_next = '0;
        if (uw.step_k)
            k_next = (k_plus1 >= key_len_eff) ? '0 : k_plus1[KIDX_W-1:0];
        if (uw.ld_a)
            a_next = rd_data_reg;
        if (uw.ld_b)
            b_next = rd_data_reg;
        // sum read may hit the entry written in the same cycle
        if (uw.ld_fwd)
            fwd_next = (sum_ab == j_reg);
        if (uw.set_seeded)
            seeded_next = 1'b1;

        unique case (uw.j_upd)
            JU_CLEAR: j_next = '0;
            JU_KS:    j_next = ks_j;
            JU_GEN:   j_next = gen_j;
            default:  j_next = j_reg;
        endcase

        if (uw.emit && emit_ok)
        begin
            ovalid_next = 1'b1;
            odata_next  = fwd_reg ? a_reg : rd_data_reg;
            olast_next  = (cnt_reg == 4'd1);
            cnt_next    = cnt_reg - 4'd1;
        end

        unique case (uw.seq)
            SQ_ACCEPT:
            begin
                if (!accept)
                    upc_next = ST_IDLE;
                else
                begin
                    cnt_next = req_cnt;
                    if (s_axis_tuser || !seeded_reg)
                        upc_next = uw.target;
                    else if (req_cnt == '0)
                        upc_next = ST_IDLE;
                    else
                        upc_next = ST_G0;
                end
            end
            SQ_POS:
            begin
                if (pos_reg != POS_LAST)
                    upc_next = uw.target;
            end
            SQ_COUNT:
            begin
                if (cnt_reg == '0)
                    upc_next = uw.target;
            end
            SQ_EMIT:
            begin
                if (!emit_ok)
                    upc_next = upc_reg;
                else if (cnt_reg > 4'd1)
                    upc_next = uw.target;
                else
                    upc_next = ST_IDLE;
            end
            default:
            begin
                upc_next = upc_reg + 4'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            len_reg    <= LEN_W'(MAX_KEY_BYTES);
            upc_reg    <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            fwd_reg    <= 1'b0;
            cnt_reg    <= '0;
            seeded_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_KEY_VALUE)
                key_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_KEY_LENGTH)
                len_reg <= cfg_data[LEN_W-1:0];
            upc_reg    <= upc_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            pos_reg    <= pos_next;
            k_reg      <= k_next;
            fwd_reg    <= fwd_next;
            cnt_reg    <= cnt_next;
            seeded_reg <= seeded_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    // byte generation only ever runs on a built permutation
    a_gen_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg >= ST_G0) |-> seeded_reg)
        else $error("byte generation without key schedule");

    // a run in progress always has bytes left
    a_gen_count: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg >= ST_G0) |-> (cnt_reg != '0))
        else $error("byte generation with zero count");

    // the byte marked last ends the run
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == ST_G4 && emit_ok && cnt_reg == 4'd1) |=> (upc_reg == ST_IDLE))
        else $error("sequencer did not return to idle after last byte");

    // schedule counter is parked at zero between requests
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == ST_IDLE) |-> (pos_reg == '0))
        else $error("position counter not parked at zero");

endmodule
